[rtl/sts_pkg.sv]
// Shared types and constants for the sorted table search unit.
// Used by sts_ctrl, sts_dp and the top module; no dependencies.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 128;
  localparam int VALUE_W             = 32;
  localparam int POS_W               = 7;
  localparam int CMD_W               = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflowed;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic load_search;
    logic issue_read;
    logic step;
    logic record_hit;
    logic emit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_empty;
    logic hit;
    logic out_busy;
  } dp_status_t;

endpackage

[rtl/sts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
`timescale 1ns / 1ps

module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/sts_ctrl.sv]
// Sequencer for the search unit: accepts requests, steps the probe loop,
// hands results to the output register. Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [sts_pkg::CMD_W-1:0] command,
  input  sts_pkg::dp_status_t      status,
  output sts_pkg::ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_CHECK   = 2'd1;
  localparam logic [1:0] S_COMPARE = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next      = state;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        cmd.clear       = accept && (command == sts_pkg::CMD_CLEAR);
        cmd.append      = accept && (command == sts_pkg::CMD_APPEND);
        cmd.load_search = accept && (command == sts_pkg::CMD_SEARCH);
        if (cmd.load_search) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.range_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.issue_read = 1'b1;
          state_next     = S_COMPARE;
        end
      end
      S_COMPARE: begin
        // read data for the probe is valid here
        if (status.hit) begin
          cmd.record_hit = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // only one datapath action per cycle
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.append, cmd.load_search, cmd.issue_read,
              cmd.step, cmd.record_hit, cmd.emit}))
    else $error("controller issued more than one action");

  // a read is always followed by its compare
  a_read_then_compare: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |=> state == S_COMPARE)
    else $error("probe read not followed by compare");

  // no new request while a search is running
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK || state == S_COMPARE) |-> !accept)
    else $error("request accepted during search");

endmodule

[rtl/sts_dp.sv]
// Datapath: entry count, overflow flag, table RAM, search bounds,
// compare and output register. Depends on sts_pkg and sts_ram.
`timescale 1ns / 1ps

module sts_dp #(
  parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [sts_pkg::VALUE_W-1:0] value,
  input  sts_pkg::ctrl_cmd_t                cmd,
  output sts_pkg::dp_status_t               status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sts_pkg::out_t                     out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0]                     count;
  logic                              overflow;
  logic [CW-1:0]                     low;
  logic [CW-1:0]                     hi_x;   // one past the upper bound
  logic [AW-1:0]                     mid;
  logic [CW-1:0]                     span;
  logic [CW-1:0]                     mid_calc;
  logic signed [sts_pkg::VALUE_W-1:0] target;
  logic                              found;
  logic                              full;
  logic [sts_pkg::VALUE_W-1:0]       rd_data;
  logic signed [sts_pkg::VALUE_W-1:0] entry;
  logic                              less;

  assign full     = (count == CW'(TABLE_DEPTH));
  assign span     = hi_x - low - CW'(1);
  assign mid_calc = low + (span >> 1);
  assign entry    = $signed(rd_data);
  assign less     = (entry < target);

  assign status.range_empty = !(low < hi_x);
  assign status.hit         = (entry == target);
  assign status.out_busy    = out_valid && !out_ready;

  sts_ram #(
    .WIDTH (sts_pkg::VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.append && !full),
    .wr_addr (count[AW-1:0]),
    .wr_data (value),
    .rd_en   (cmd.issue_read),
    .rd_addr (mid_calc[AW-1:0]),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (cmd.append) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    if (cmd.load_search) begin
      low    <= '0;
      hi_x   <= count;
      target <= value;
      found  <= 1'b0;
    end
    if (cmd.issue_read) begin
      mid <= mid_calc[AW-1:0];
    end
    if (cmd.step) begin
      if (less) begin
        low <= CW'(mid) + CW'(1);
      end else begin
        hi_x <= CW'(mid);
      end
    end
    if (cmd.record_hit) begin
      found <= 1'b1;
    end
    if (cmd.emit) begin
      out_data.found      <= found;
      out_data.position   <= found ? sts_pkg::POS_W'(mid) : '0;
      out_data.overflowed <= overflow;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue_read || cmd.step) |-> (low <= hi_x && hi_x <= count))
    else $error("search bounds out of order");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("result overwrote a pending result");

  a_overflow_when_full: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow) |-> count == CW'(TABLE_DEPTH))
    else $error("overflow raised on a table that is not full");

endmodule

[rtl/sorted_table_binary_search_unit.sv]
// Sorted table search unit: clear / append / search requests on one channel,
// one result per search on the other.
// Requests carry sts_pkg::in_t, results sts_pkg::out_t (valid/ready each).
// Clear and append finish in the cycle they are accepted and give no result.
// A search runs the binary probe loop over the appended entries; each probe
// is one registered read of the table RAM plus one compare.
// Searches are handled one at a time; the next request is taken as
// soon as the result is loaded into the output register, even if
// the receiver has not yet taken it.
// If the receiver stalls, the result holds in the output register and a
// following search waits after its last probe until that register frees.
// Reset empties the table (count and overflow flag to zero), drops any
// pending result and returns the sequencer to idle; RAM contents are not
// cleared, no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sts_pkg::out_t out_data
);

  sts_pkg::ctrl_cmd_t  cmd;
  sts_pkg::dp_status_t status;

  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (in_data.command),
    .status   (status),
    .cmd      (cmd)
  );

  sts_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (in_data.value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
